[src/mexp_pkg.sv]
`default_nettype none
package mexp_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned CNT_W     = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic load;
    logic step;
  } seq_ctrl_t;

  localparam cnt_t LAST_STEP = CNT_W'(WORD_BITS - 1);

endpackage
`default_nettype wire

[src/mexp_reduce.sv]
`default_nettype none
module mexp_reduce (
  input  wire                      clk_i,
  input  wire mexp_pkg::seq_ctrl_t ctrl_i,
  input  wire mexp_pkg::word_t     dividend_i,
  input  wire mexp_pkg::word_t     modulus_i,
  output mexp_pkg::word_t          rem_o
);

  mexp_pkg::word_t rem_q, rem_d;
  mexp_pkg::word_t div_q, div_d;
  logic [mexp_pkg::WORD_BITS:0] trial;
  logic [mexp_pkg::WORD_BITS:0] trial_sub;

  // restoring division, one dividend bit per cycle while step is asserted, msb first
  always_comb begin
    trial     = {rem_q, div_q[mexp_pkg::WORD_BITS-1]};
    trial_sub = trial - {1'b0, modulus_i};
    rem_d     = rem_q;
    div_d     = div_q;
    if (ctrl_i.load) begin
      rem_d = '0;
      div_d = dividend_i;
    end else if (ctrl_i.step) begin
      rem_d = (trial >= {1'b0, modulus_i}) ? trial_sub[mexp_pkg::WORD_BITS-1:0]
                                           : trial[mexp_pkg::WORD_BITS-1:0];
      div_d = {div_q[mexp_pkg::WORD_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rem_o = rem_q;

endmodule
`default_nettype wire

[src/mexp_mulmod.sv]
`default_nettype none
module mexp_mulmod (
  input  wire                      clk_i,
  input  wire mexp_pkg::seq_ctrl_t ctrl_i,
  input  wire mexp_pkg::word_t     x_i,
  input  wire mexp_pkg::word_t     y_i,
  input  wire mexp_pkg::word_t     modulus_i,
  output mexp_pkg::word_t          prod_o
);

  mexp_pkg::word_t acc_q, acc_d;
  mexp_pkg::word_t x_q, x_d;
  mexp_pkg::word_t y_q, y_d;
  logic [mexp_pkg::WORD_BITS:0] sum;
  logic [mexp_pkg::WORD_BITS:0] sum_sub;
  logic [mexp_pkg::WORD_BITS:0] dbl;
  logic [mexp_pkg::WORD_BITS:0] dbl_sub;
  logic [mexp_pkg::WORD_BITS:0] mod_ext;

  // acc and x both stay below the modulus, so one subtract keeps them reduced
  always_comb begin
    mod_ext = {1'b0, modulus_i};
    sum     = {1'b0, acc_q} + {1'b0, x_q};
    sum_sub = sum - mod_ext;
    dbl     = {x_q, 1'b0};
    dbl_sub = dbl - mod_ext;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    if (ctrl_i.load) begin
      acc_d = '0;
      x_d   = x_i;
      y_d   = y_i;
    end else if (ctrl_i.step) begin
      if (y_q[0]) begin
        acc_d = (sum >= mod_ext) ? sum_sub[mexp_pkg::WORD_BITS-1:0]
                                 : sum[mexp_pkg::WORD_BITS-1:0];
      end
      x_d = (dbl >= mod_ext) ? dbl_sub[mexp_pkg::WORD_BITS-1:0]
                             : dbl[mexp_pkg::WORD_BITS-1:0];
      y_d = {1'b0, y_q[mexp_pkg::WORD_BITS-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign prod_o = acc_q;

endmodule
`default_nettype wire

[src/modular_exponentiation_64_unit.sv]
// sequence: input beat, 64 reduction steps, base set, then per exponent bit over all 64 bits
//   a load, a multiply pass and an end step; bounded by the bit-serial multipliers
// modulus 0 or 1 skips reduction and multiplication and goes from the input beat straight to finish
// throughput: one item at a time; a new beat is taken while a result waits
// reset: asynchronous active low, clears control and valid flags only
`default_nettype none
module modular_exponentiation_64_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [63:0] base_value_i,
  input  wire  [63:0] exponent_i,
  input  wire  [63:0] modulus_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [63:0] power_mod_o,
  output logic        zero_modulus_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_SETB   = 3'd2;
  localparam logic [2:0] ST_MLOAD  = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_MEND   = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0]      state_q, state_d;
  mexp_pkg::cnt_t  cnt_q, cnt_d;
  mexp_pkg::cnt_t  exp_cnt_q, exp_cnt_d;
  logic            out_valid_q, out_valid_d;

  mexp_pkg::word_t m_q, e_q, r_q, b_q;
  logic            zm_q;
  logic [63:0]     power_mod_q;
  logic            zero_modulus_q;

  mexp_pkg::word_t   in_base, in_exp, in_mod;
  mexp_pkg::word_t   red_rem, prod_rb, prod_bb;
  mexp_pkg::seq_ctrl_t red_ctrl, mul_ctrl;
  logic in_beat, out_free, trivial;

  assign in_base = base_value_i[mexp_pkg::WORD_BITS-1:0];
  assign in_exp  = exponent_i[mexp_pkg::WORD_BITS-1:0];
  assign in_mod  = modulus_i[mexp_pkg::WORD_BITS-1:0];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign trivial    = (in_mod <= mexp_pkg::word_t'(1));

  mexp_reduce u_reduce (
    .clk_i      (clk_i),
    .ctrl_i     (red_ctrl),
    .dividend_i (in_base),
    .modulus_i  (m_q),
    .rem_o      (red_rem)
  );

  // running result times base power
  mexp_mulmod u_mul_rb (
    .clk_i     (clk_i),
    .ctrl_i    (mul_ctrl),
    .x_i       (r_q),
    .y_i       (b_q),
    .modulus_i (m_q),
    .prod_o    (prod_rb)
  );

  // base power squared
  mexp_mulmod u_mul_bb (
    .clk_i     (clk_i),
    .ctrl_i    (mul_ctrl),
    .x_i       (b_q),
    .y_i       (b_q),
    .modulus_i (m_q),
    .prod_o    (prod_bb)
  );

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    exp_cnt_d     = exp_cnt_q;
    out_valid_d   = out_valid_q;
    red_ctrl      = '0;
    mul_ctrl      = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          cnt_d     = '0;
          exp_cnt_d = '0;
          if (trivial) begin
            state_d = ST_FIN;
          end else begin
            red_ctrl.load = 1'b1;
            state_d       = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        red_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == mexp_pkg::LAST_STEP) begin
          state_d = ST_SETB;
        end
      end
      ST_SETB: begin
        state_d = ST_MLOAD;
      end
      ST_MLOAD: begin
        mul_ctrl.load = 1'b1;
        cnt_d         = '0;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        mul_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == mexp_pkg::LAST_STEP) begin
          state_d = ST_MEND;
        end
      end
      ST_MEND: begin
        exp_cnt_d = exp_cnt_q + 1'b1;
        state_d   = (exp_cnt_q == mexp_pkg::LAST_STEP) ? ST_FIN : ST_MLOAD;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      exp_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      exp_cnt_q   <= exp_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_beat) begin
      m_q  <= in_mod;
      e_q  <= in_exp;
      zm_q <= (in_mod == '0);
      r_q  <= trivial ? '0 : mexp_pkg::word_t'(1);
    end
    if (state_q == ST_SETB) begin
      b_q <= red_rem;
    end
    if (state_q == ST_MEND) begin
      if (e_q[0]) begin
        r_q <= prod_rb;
      end
      b_q <= prod_bb;
      e_q <= {1'b0, e_q[mexp_pkg::WORD_BITS-1:1]};
    end
    if (state_q == ST_FIN && out_free) begin
      power_mod_q    <= 64'(r_q);
      zero_modulus_q <= zm_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign power_mod_o    = power_mod_q;
  assign zero_modulus_o = zero_modulus_q;

endmodule
`default_nettype wire
